// ===== rtl/core/vertex_hemispheric_lighting_core_macros.svh =====
// assertion macros shared by the lighting core rtl
// no dependencies; included by files that carry concurrent checks
`ifndef VERTEX_HEMISPHERIC_LIGHTING_CORE_MACROS_SVH
`define VERTEX_HEMISPHERIC_LIGHTING_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VHL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vhl check failed");
// next-cycle implication
`define VHL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vhl check failed");
`else
`define VHL_ASSERT_IMP(label, clk, rst, ante, cons)
`define VHL_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/vhl_pkg.sv =====
// shared types and constants for the vertex lighting core
// no dependencies; imported by every core module
package vhl_pkg;

   // register indexes on the csr channel
   localparam logic [2:0] CSR_AMBIENT = 3'd0;
   localparam logic [2:0] CSR_SHADE   = 3'd1;
   localparam logic [2:0] CSR_WRAP    = 3'd2;
   localparam logic [2:0] CSR_COLOR_R = 3'd3;
   localparam logic [2:0] CSR_COLOR_G = 3'd4;
   localparam logic [2:0] CSR_COLOR_B = 3'd5;

   // shade_mode bits
   localparam int MODE_FLAT_BIT       = 0;
   localparam int MODE_FULLBRIGHT_BIT = 1;

   localparam logic [14:0] ONE_Q14   = 15'd16384;
   localparam logic [14:0] AMB_FLOOR = 15'd1638;
   localparam logic [15:0] WRAP_ONE  = 16'd4096;
   localparam logic [32:0] DOT_ONE   = 33'd268435456;  // 1.0 in q2.28
   localparam int          DIV_BITS  = 15;             // quotient bits of the wrap term

   typedef struct packed {
      logic [1:0]         shade_mode;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [15:0] bone_light_x;
      logic signed [15:0] bone_light_y;
      logic signed [15:0] bone_light_z;
   } req_type;

   typedef struct packed {
      logic [1:0]  shade_mode;
      logic [32:0] numer;
   } dot_out_type;

   typedef struct packed {
      logic [1:0]  shade_mode;
      logic [14:0] term;
   } div_out_type;

   typedef struct packed {
      logic [14:0] light_red;
      logic [14:0] light_green;
      logic [14:0] light_blue;
   } rsp_type;

   typedef struct packed {
      logic [14:0] amb;
      logic [14:0] shd;
      logic [15:0] amb_shd;
      logic [14:0] flat;
      logic [32:0] div_k;
      logic [17:0] div_d;
      logic [14:0] color_r;
      logic [14:0] color_g;
      logic [14:0] color_b;
   } cfg_type;

endpackage

// ===== rtl/core/vhl_req_if.sv =====
// request channel of the vertex lighting core
// standalone interface, no package needed
interface vhl_req_if ();
   logic               valid;
   logic               ready;
   logic [1:0]         shade_mode;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic signed [15:0] bone_light_x;
   logic signed [15:0] bone_light_y;
   logic signed [15:0] bone_light_z;

   modport source (output valid, shade_mode, normal_x, normal_y, normal_z,
                   bone_light_x, bone_light_y, bone_light_z, input ready);
   modport sink (input valid, shade_mode, normal_x, normal_y, normal_z,
                 bone_light_x, bone_light_y, bone_light_z, output ready);
endinterface

// ===== rtl/core/vhl_rsp_if.sv =====
// response channel of the vertex lighting core
// standalone interface, no package needed
interface vhl_rsp_if ();
   logic        valid;
   logic        ready;
   logic [14:0] light_red;
   logic [14:0] light_green;
   logic [14:0] light_blue;

   modport source (output valid, light_red, light_green, light_blue, input ready);
   modport sink (input valid, light_red, light_green, light_blue, output ready);
endinterface

// ===== rtl/core/vhl_csr_if.sv =====
// register write channel of the vertex lighting core
// standalone interface, no package needed
interface vhl_csr_if ();
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/vhl_csr.sv =====
// register file and derived lighting constants
// depends on vhl_pkg and vhl_csr_if
module vhl_csr import vhl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   vhl_csr_if.sink   csr_bus,
   output cfg_type   cfg
);

   logic [7:0]  amb_lvl_ff, amb_lvl_in;
   logic [7:0]  shd_lvl_ff, shd_lvl_in;
   logic [15:0] wrap_ff, wrap_in;
   logic [14:0] col_r_ff, col_r_in;
   logic [14:0] col_g_ff, col_g_in;
   logic [14:0] col_b_ff, col_b_in;

   logic [14:0] amb_q_ff, amb_q_in;
   logic [14:0] shd_q_ff, shd_q_in;
   logic [32:0] div_k_ff, div_k_in;
   logic [17:0] div_d_ff, div_d_in;
   logic [15:0] amb_shd_ff, amb_shd_in;
   logic [14:0] flat_ff, flat_in;

   logic [15:0] wrap_eff;
   logic [17:0] flat_num;
   logic [33:0] flat_prod;
   logic [14:0] flat_est;
   logic [17:0] flat_rem;

   // round(b * 16384 / 255) = 64b + floor((64b + 127) / 255)
   function automatic logic [14:0] byte_to_q14(input logic [7:0] b);
      logic [14:0] z;
      logic [22:0] prod;
      logic [6:0]  est;
      logic [14:0] rem;
      z    = 15'({b, 6'b0}) + 15'd127;
      prod = 23'(z) * 23'd257;
      est  = prod[22:16];
      rem  = z - 15'(est) * 15'd255;
      if (rem >= 15'd255) begin
         est = est + 7'd1;
      end
      return 15'({b, 6'b0}) + 15'(est);
   endfunction

   assign csr_bus.ready = 1'b1;

   always_comb begin
      amb_lvl_in = amb_lvl_ff;
      shd_lvl_in = shd_lvl_ff;
      wrap_in    = wrap_ff;
      col_r_in   = col_r_ff;
      col_g_in   = col_g_ff;
      col_b_in   = col_b_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_AMBIENT: amb_lvl_in = csr_bus.data[7:0];
            CSR_SHADE:   shd_lvl_in = csr_bus.data[7:0];
            CSR_WRAP:    wrap_in    = csr_bus.data;
            CSR_COLOR_R: col_r_in   = csr_bus.data[14:0];
            CSR_COLOR_G: col_g_in   = csr_bus.data[14:0];
            CSR_COLOR_B: col_b_in   = csr_bus.data[14:0];
            default: ;
         endcase
      end
   end

   // first derived layer: byte scaling and divider constants
   always_comb begin
      amb_q_in = byte_to_q14(amb_lvl_ff);
      if (amb_q_in < AMB_FLOOR) begin
         amb_q_in = AMB_FLOOR;
      end
      shd_q_in = byte_to_q14(shd_lvl_ff);
      wrap_eff = (wrap_ff < WRAP_ONE) ? WRAP_ONE : wrap_ff;
      div_d_in = {wrap_eff, 2'b00};
      // numerator offset: wrap * 2^16 - 2^28 plus the rounding half 2 * wrap
      div_k_in = 33'({wrap_eff, 16'b0}) + 33'({wrap_eff, 1'b0}) - DOT_ONE;
   end

   // second derived layer: flat level ambient + round(0.8 * shade)
   always_comb begin
      flat_num  = 18'({shd_q_ff, 3'b0}) + 18'd5;
      flat_prod = 34'(flat_num) * 34'd52428;
      flat_est  = flat_prod[33:19];
      flat_rem  = flat_num - 18'(flat_est) * 18'd10;
      if (flat_rem >= 18'd10) begin
         flat_est = flat_est + 15'd1;
      end
      flat_in    = amb_q_ff + flat_est;
      amb_shd_in = 16'(amb_q_ff) + 16'(shd_q_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amb_lvl_ff <= 8'd32;
         shd_lvl_ff <= 8'd192;
         wrap_ff    <= 16'd6144;
         col_r_ff   <= ONE_Q14;
         col_g_ff   <= ONE_Q14;
         col_b_ff   <= ONE_Q14;
      end else begin
         amb_lvl_ff <= amb_lvl_in;
         shd_lvl_ff <= shd_lvl_in;
         wrap_ff    <= wrap_in;
         col_r_ff   <= col_r_in;
         col_g_ff   <= col_g_in;
         col_b_ff   <= col_b_in;
      end
   end

   always_ff @(posedge clock) begin
      amb_q_ff   <= amb_q_in;
      shd_q_ff   <= shd_q_in;
      div_k_ff   <= div_k_in;
      div_d_ff   <= div_d_in;
      amb_shd_ff <= amb_shd_in;
      flat_ff    <= flat_in;
   end

   always_comb begin
      cfg.amb     = amb_q_ff;
      cfg.shd     = shd_q_ff;
      cfg.amb_shd = amb_shd_ff;
      cfg.flat    = flat_ff;
      cfg.div_k   = div_k_ff;
      cfg.div_d   = div_d_ff;
      cfg.color_r = col_r_ff;
      cfg.color_g = col_g_ff;
      cfg.color_b = col_b_ff;
   end

endmodule

// ===== rtl/core/vhl_dot.sv =====
// dot product front end: products, sum, clamp and wrap numerator
// depends on vhl_pkg
module vhl_dot import vhl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  req_type     in_data,
   input  logic [32:0] div_k,
   output logic        out_valid,
   input  logic        out_ready,
   output dot_out_type out_data
);

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic rdy1, rdy2, rdy3;

   logic [1:0]         mode1_ff, mode2_ff, mode3_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic signed [31:0] px_in, py_in, pz_in;
   logic signed [33:0] dot_ff, dot_in;
   logic signed [33:0] dot_clamp;
   logic signed [34:0] num_full;
   logic [32:0]        numer_ff, numer_in;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign v1_in = rdy1 ? in_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_comb begin
      px_in = 32'(in_data.normal_x) * 32'(in_data.bone_light_x);
      py_in = 32'(in_data.normal_y) * 32'(in_data.bone_light_y);
      pz_in = 32'(in_data.normal_z) * 32'(in_data.bone_light_z);
      dot_in = 34'(px_ff) + 34'(py_ff) + 34'(pz_ff);
      dot_clamp = (dot_ff > $signed({1'b0, DOT_ONE})) ? $signed({1'b0, DOT_ONE}) : dot_ff;
      num_full  = 35'(dot_clamp) + $signed({2'b00, div_k});
      // a negative numerator gives a zero term
      numer_in  = num_full[34] ? '0 : num_full[32:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         mode1_ff <= in_data.shade_mode;
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
      end
      if (rdy2) begin
         mode2_ff <= mode1_ff;
         dot_ff   <= dot_in;
      end
      if (rdy3) begin
         mode3_ff <= mode2_ff;
         numer_ff <= numer_in;
      end
   end

   assign out_valid           = v3_ff;
   assign out_data.shade_mode = mode3_ff;
   assign out_data.numer      = numer_ff;

endmodule

// ===== rtl/core/vhl_div.sv =====
// pipelined restoring divider for the wrap term, one quotient bit per stage
// depends on vhl_pkg and the assertion macro header
`include "vertex_hemispheric_lighting_core_macros.svh"
module vhl_div import vhl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  dot_out_type in_data,
   input  logic [17:0] div_d,
   output logic        out_valid,
   input  logic        out_ready,
   output div_out_type out_data
);

   logic        v_ff    [DIV_BITS];
   logic [32:0] rem_ff  [DIV_BITS];
   logic [14:0] q_ff    [DIV_BITS];
   logic [1:0]  mode_ff [DIV_BITS];
   logic        rdy     [DIV_BITS+1];

   assign rdy[DIV_BITS] = out_ready;
   assign in_ready      = rdy[0];

   for (genvar j = 0; j < DIV_BITS; j++) begin : g_stage
      localparam int BIT = DIV_BITS - 1 - j;
      logic        v_prev;
      logic [32:0] rem_prev;
      logic [14:0] q_prev;
      logic [1:0]  mode_prev;
      logic [32:0] shifted;
      logic        take;
      logic [32:0] rem_in;
      logic [14:0] q_in;
      logic        v_in;

      if (j == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = in_data.numer;
         assign q_prev    = '0;
         assign mode_prev = in_data.shade_mode;
      end else begin : g_next
         assign v_prev    = v_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign q_prev    = q_ff[j-1];
         assign mode_prev = mode_ff[j-1];
      end

      assign rdy[j] = !v_ff[j] || rdy[j+1];

      always_comb begin
         shifted = 33'(div_d) << BIT;
         take    = rem_prev >= shifted;
         rem_in  = take ? rem_prev - shifted : rem_prev;
         q_in    = q_prev | (15'(take) << BIT);
         v_in    = rdy[j] ? v_prev : v_ff[j];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_in;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[j]) begin
            rem_ff[j]  <= rem_in;
            q_ff[j]    <= q_in;
            mode_ff[j] <= mode_prev;
         end
      end
   end

   assign out_valid           = v_ff[DIV_BITS-1];
   assign out_data.term       = q_ff[DIV_BITS-1];
   assign out_data.shade_mode = mode_ff[DIV_BITS-1];

   // the clamped dot product keeps the term within 1.0
   `VHL_ASSERT_IMP(a_term_range, clock, reset, out_valid, out_data.term <= ONE_Q14)
   // quotient width suffices: the final remainder is below the divisor
   `VHL_ASSERT_IMP(a_rem_below, clock, reset, out_valid, rem_ff[DIV_BITS-1] < 33'(div_d))
   // a stalled result stays put
   `VHL_ASSERT_NXT(a_stall_hold, clock, reset, out_valid && !out_ready,
                   out_valid && $stable(out_data))

endmodule

// ===== rtl/core/vhl_shade.sv =====
// shading back end: shade subtraction, mode selection, level clamp and color scaling
// depends on vhl_pkg
module vhl_shade import vhl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  div_out_type in_data,
   input  cfg_type     cfg,
   output logic        out_valid,
   input  logic        out_ready,
   output rsp_type     out_data
);

   logic va_ff, va_in, vb_ff, vb_in, vc_ff, vc_in;
   logic rdya, rdyb, rdyc;

   logic [1:0]  mode_a_ff;
   logic [14:0] sub_ff, sub_in;
   logic [28:0] sub_prod;
   logic        full_b_ff, full_b_in;
   logic [14:0] illum_ff, illum_in;
   logic [15:0] diff;
   rsp_type     rsp_ff, rsp_in;

   function automatic logic [14:0] scale_q14(input logic [14:0] a, input logic [14:0] b);
      logic [29:0] p;
      p = 30'(a) * 30'(b) + 30'd8192;
      return p[28:14];
   endfunction

   assign rdyc     = !vc_ff || out_ready;
   assign rdyb     = !vb_ff || rdyc;
   assign rdya     = !va_ff || rdyb;
   assign in_ready = rdya;

   assign va_in = rdya ? in_valid : va_ff;
   assign vb_in = rdyb ? va_ff : vb_ff;
   assign vc_in = rdyc ? vb_ff : vc_ff;

   always_comb begin
      sub_prod = 29'(in_data.term) * 29'(cfg.shd) + 29'd8192;
      sub_in   = sub_prod[28:14];

      full_b_in = mode_a_ff[MODE_FULLBRIGHT_BIT];
      diff      = (cfg.amb_shd > 16'(sub_ff)) ? cfg.amb_shd - 16'(sub_ff) : '0;
      if (mode_a_ff[MODE_FLAT_BIT]) begin
         illum_in = (cfg.flat > ONE_Q14) ? ONE_Q14 : cfg.flat;
      end else begin
         illum_in = (diff > 16'(ONE_Q14)) ? ONE_Q14 : diff[14:0];
      end

      if (full_b_ff) begin
         rsp_in.light_red   = ONE_Q14;
         rsp_in.light_green = ONE_Q14;
         rsp_in.light_blue  = ONE_Q14;
      end else begin
         rsp_in.light_red   = scale_q14(illum_ff, cfg.color_r);
         rsp_in.light_green = scale_q14(illum_ff, cfg.color_g);
         rsp_in.light_blue  = scale_q14(illum_ff, cfg.color_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdya) begin
         mode_a_ff <= in_data.shade_mode;
         sub_ff    <= sub_in;
      end
      if (rdyb) begin
         full_b_ff <= full_b_in;
         illum_ff  <= illum_in;
      end
      if (rdyc) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_data  = rsp_ff;

endmodule

// ===== rtl/core/vertex_hemispheric_lighting_core.sv =====
// vertex lighting core: takes one vertex per clock, sustained if nothing stalls,
// and returns its rgb light level. a result passes 3 stages of dot product and
// numerator, 15 divider stages (one quotient bit of the wrap term per stage, which
// sets the latency) and 3 shading stages ending in the response register. every
// stage holds its own valid bit and loads when empty or when its successor moves,
// so bubbles close up and a request is still taken while a finished result waits
// if some stage is empty. register writes pass the register file and then the
// derived constant registers; the user must make them only while no vertex is in
// flight, which the block does not enforce. depends on vhl_pkg, the three channel
// interfaces and the vhl_csr, vhl_dot, vhl_div and vhl_shade modules
module vertex_hemispheric_lighting_core import vhl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   vhl_req_if.sink    req_bus,
   vhl_rsp_if.source  rsp_bus,
   vhl_csr_if.sink    csr_bus
);

   cfg_type     cfg;
   req_type     req_data;
   dot_out_type dot_data;
   div_out_type div_data;
   rsp_type     rsp_data;

   logic dot_valid, dot_ready;
   logic div_valid, div_ready;

   // pack the request fields for the front end
   always_comb begin
      req_data.shade_mode   = req_bus.shade_mode;
      req_data.normal_x     = req_bus.normal_x;
      req_data.normal_y     = req_bus.normal_y;
      req_data.normal_z     = req_bus.normal_z;
      req_data.bone_light_x = req_bus.bone_light_x;
      req_data.bone_light_y = req_bus.bone_light_y;
      req_data.bone_light_z = req_bus.bone_light_z;
   end

   // registers and the constants derived from them
   vhl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // normal . light, clamped to 1.0, turned into the divider numerator
   vhl_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (req_data),
      .div_k     (cfg.div_k),
      .out_valid (dot_valid),
      .out_ready (dot_ready),
      .out_data  (dot_data)
   );

   // wrap term = rounded numerator / (4 * wrap)
   vhl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dot_valid),
      .in_ready  (dot_ready),
      .in_data   (dot_data),
      .div_d     (cfg.div_d),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   // level selection by mode, clamp and color scaling into the response register
   vhl_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .cfg       (cfg),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   // unpack the response
   assign rsp_bus.light_red   = rsp_data.light_red;
   assign rsp_bus.light_green = rsp_data.light_green;
   assign rsp_bus.light_blue  = rsp_data.light_blue;

endmodule
